[sv/spfr_pkg.sv]
// Package: shared types, constants and frame helpers for the sensor poll frame responder.
`timescale 1ns / 1ps
package spfr_pkg;

  localparam int FrameLen = 8;
  localparam int AddrW = 4;

  localparam logic [7:0] FrameHeader = 8'h10;
  localparam logic [7:0] PollIdReset = 8'h1B;
  localparam logic [15:0] SensorIdReset = 16'h0100;
  localparam logic signed [31:0] SensorValueReset = 32'sd1260;

  typedef enum logic [1:0] {
    REG_POLL_ID      = 2'd0,
    REG_SENSOR_ID    = 2'd1,
    REG_SENSOR_VALUE = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]         poll_id;
    logic [15:0]        sensor_id;
    logic signed [31:0] sensor_value;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } cell_t;

  typedef logic [FrameLen-1:0][7:0] frame_t;

  function automatic logic [7:0] frame_checksum(input frame_t f);
    logic [10:0] sum;
    logic [8:0]  fold;
    logic [7:0]  folded;
    sum = 11'd0;
    for (int k = 0; k < FrameLen - 1; k++) begin
      sum = sum + {3'd0, f[k]};
    end
    fold = {1'b0, sum[7:0]} + {6'd0, sum[10:8]};
    folded = fold[7:0] + {7'd0, fold[8]};
    return 8'hFF - folded;
  endfunction

  function automatic frame_t frame_build(input cfg_t c);
    frame_t f;
    f = '0;
    f[0] = FrameHeader;
    f[1] = c.sensor_id[7:0];
    f[2] = c.sensor_id[15:8];
    f[3] = c.sensor_value[7:0];
    f[4] = c.sensor_value[15:8];
    f[5] = c.sensor_value[23:16];
    f[6] = c.sensor_value[31:24];
    f[FrameLen-1] = frame_checksum(f);
    return f;
  endfunction

endpackage

[sv/spfr_regs.sv]
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module spfr_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [spfr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output spfr_pkg::cfg_t            cfg
);
  import spfr_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_id <= PollIdReset;
      cfg.sensor_id <= SensorIdReset;
      cfg.sensor_value <= SensorValueReset;
    end else if (wr) begin
      unique case (idx)
        REG_POLL_ID:      cfg.poll_id <= pwdata[7:0];
        REG_SENSOR_ID:    cfg.sensor_id <= pwdata[15:0];
        REG_SENSOR_VALUE: cfg.sensor_value <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POLL_ID:      prdata = {24'd0, cfg.poll_id};
      REG_SENSOR_ID:    prdata = {16'd0, cfg.sensor_id};
      REG_SENSOR_VALUE: prdata = cfg.sensor_value;
      default:          prdata = 32'd0;
    endcase
  end

endmodule

[sv/spfr_cell.sv]
// One byte cell of the transmit chain: parallel load or shift from the upstream cell.
`timescale 1ns / 1ps
module spfr_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                shift,
  input  logic [7:0]          load_data,
  input  logic                load_last,
  input  spfr_pkg::cell_t     upstream,
  output spfr_pkg::cell_t     held
);
  import spfr_pkg::*;

  logic       valid;
  logic [7:0] data;
  logic       last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (shift) begin
      valid <= upstream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
      last <= load_last;
    end else if (shift) begin
      data <= upstream.data;
      last <= upstream.last;
    end
  end

  assign held = '{valid: valid, data: data, last: last};

endmodule

[sv/sensor_poll_frame_responder_top.sv]
// Top level: poll matcher, frame loader and the chain of transmit cells.
//
// Usage: received line bytes arrive on the in channel (in_valid, in_ready,
// line_byte) and are held one at a time in an input register. A byte equal
// to poll_id loads an 8-byte response frame into a chain of eight cells in
// parallel; other bytes are dropped the cycle after their transfer.
// The chain shifts one byte towards the out channel (out_valid, out_ready,
// tx_byte, frame_end) on each output transfer; frame_end marks the
// checksum byte.
// With the chain free, a poll byte passes from the input register into
// the chain, whose first cell then offers the first frame byte.
// Throughput: one output byte per cycle while out_ready is high; a poll is
// taken when the eight-byte chain reloads as its last byte leaves, so
// frames follow one another with no gap. Non-matching bytes flow at one
// per cycle unless a poll waits in the input register.
// Reset: chain and input register empty, registers at 0x1B, 0x0100, 1260.
// Stall: with a byte offered and out_ready low the chain holds; a pending
// poll waits in the input register and in_ready drops until the chain can reload.
// Configuration: APB-style, poll_id at 0x0, sensor_id at 0x4,
// sensor_value at 0x8.
`timescale 1ns / 1ps
module sensor_poll_frame_responder_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spfr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 line_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 tx_byte,
  output logic                       frame_end
);
  import spfr_pkg::*;

  cfg_t       cfg;
  frame_t     frame;
  cell_t      chain [FrameLen];
  cell_t      feed  [FrameLen];
  logic       pend_valid;
  logic [7:0] pend_byte;
  logic       pend_match;
  logic       pend_take;
  logic       chain_free;
  logic       upper_busy;
  logic       load;
  logic       shift;

  assign pready = 1'b1;

  spfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  always_comb begin
    upper_busy = 1'b0;
    for (int k = 1; k < FrameLen; k++) begin
      upper_busy = upper_busy | chain[k].valid;
    end
  end

  assign shift = out_ready || !chain[0].valid;
  assign chain_free = !upper_busy && shift;
  assign pend_match = pend_byte == cfg.poll_id;
  assign load = pend_valid && pend_match && chain_free;
  assign pend_take = pend_valid && (!pend_match || chain_free);
  assign in_ready = !pend_valid || pend_take;
  assign frame = frame_build(cfg);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_ready) begin
      pend_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pend_byte <= line_byte;
    end
  end

  for (genvar i = 0; i < FrameLen; i++) begin : g_cell
    if (i == FrameLen - 1) begin : g_tail
      assign feed[i] = '0;
    end else begin : g_body
      assign feed[i] = chain[i+1];
    end

    spfr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (load),
      .shift     (shift),
      .load_data (frame[i]),
      .load_last (i == FrameLen - 1),
      .upstream  (feed[i]),
      .held      (chain[i])
    );
  end

  assign out_valid = chain[0].valid;
  assign tx_byte = chain[0].data;
  assign frame_end = chain[0].last;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench: drives line bytes and register writes, checks every reply frame byte by byte.
module tb;
  import spfr_pkg::*;

  localparam int SettleCycles = 4;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        line_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        tx_byte;
  logic              frame_end;

  logic [7:0]        poll_match = PollIdReset;
  logic [15:0]       id_word = SensorIdReset;
  logic signed [31:0] value_word = SensorValueReset;

  reply_beat_t       reply_q[$];
  reply_beat_t       want;
  int                errors = 0;
  int                cycles = 0;
  int                stall_left = 0;
  bit                calm = 1'b0;

  sensor_poll_frame_responder_top dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .line_byte (line_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tx_byte   (tx_byte),
    .frame_end (frame_end)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("cycle %0d: %s", cycles, what);
  endtask

  function automatic void predict_reply(input logic [7:0] rx);
    logic [7:0] body [FrameLen];
    int sum;
    if (rx != poll_match) return;
    body[0] = FrameHeader;
    body[1] = id_word[7:0];
    body[2] = id_word[15:8];
    body[3] = value_word[7:0];
    body[4] = value_word[15:8];
    body[5] = value_word[23:16];
    body[6] = value_word[31:24];
    sum = 0;
    for (int k = 0; k < FrameLen - 1; k++) sum += body[k];
    // fold carries back into the low byte
    while (sum > 255) sum = (sum & 255) + (sum >> 8);
    body[FrameLen-1] = 8'hFF - 8'(sum);
    for (int k = 0; k < FrameLen; k++) begin
      reply_q.push_back('{data: body[k], last: (k == FrameLen - 1)});
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer tx_byte=%02h frame_end=%0b",
                                  tx_byte, frame_end));
      end else begin
        want = reply_q.pop_front();
        if (tx_byte !== want.data)
          report_mismatch($sformatf("tx_byte %02h, predicted %02h", tx_byte, want.data));
        if (frame_end !== want.last)
          report_mismatch($sformatf("frame_end %0b, predicted %0b", frame_end, want.last));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    line_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_reply(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POLL_ID:      poll_match = data[7:0];
      REG_SENSOR_ID:    id_word = data[15:0];
      REG_SENSOR_VALUE: value_word = data;
      default: ;
    endcase
  endtask

  task automatic test_reset_values();
    send_byte(8'h1B);
    send_byte(8'h1A);
    send_byte(8'h1C);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h1B);
    send_byte(8'h1B);
    drain();
  endtask

  task automatic test_register_extremes();
    cfg_write(REG_POLL_ID, 32'h0);
    cfg_write(REG_SENSOR_ID, 32'h0);
    cfg_write(REG_SENSOR_VALUE, 32'h0);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h00);
    drain();
    cfg_write(REG_POLL_ID, 32'hFF);
    cfg_write(REG_SENSOR_ID, 32'hFFFF);
    cfg_write(REG_SENSOR_VALUE, 32'h7FFF_FFFF);
    send_byte(8'hFF);
    send_byte(8'hFE);
    drain();
    cfg_write(REG_SENSOR_VALUE, 32'h8000_0000);
    send_byte(8'hFF);
    drain();
    cfg_write(REG_SENSOR_VALUE, 32'hFFFF_FFFF);
    send_byte(8'hFF);
    drain();
    // write to an unmapped address must leave every register alone
    cfg_write(REG_NONE, $urandom());
    send_byte(8'hFF);
    send_byte(8'h1B);
    drain();
  endtask

  task automatic test_stray_bits();
    cfg_write(REG_POLL_ID, 32'hABCD_E13C);
    cfg_write(REG_SENSOR_ID, 32'hDEAD_1234);
    send_byte(8'h3C);
    send_byte(8'h13);
    drain();
  endtask

  task automatic test_poll_pause();
    for (int i = 0; i < 3; i++) begin
      send_byte(poll_match);
      drain();
    end
  endtask

  task automatic test_random(input int phases, input int per_phase);
    logic [31:0] v;
    for (int p = 0; p < phases; p++) begin
      drain();
      if (p == phases - 1) calm = 1'b1;
      case ($urandom_range(0, 3))
        0:       v = 32'h0;
        1:       v = 32'hFF;
        default: v = $urandom();
      endcase
      cfg_write(REG_POLL_ID, v);
      cfg_write(REG_SENSOR_ID, $urandom());
      case ($urandom_range(0, 5))
        0:       v = 32'h0;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'h8000_0000;
        3:       v = 32'hFFFF_FFFF;
        default: v = $urandom();
      endcase
      cfg_write(REG_SENSOR_VALUE, v);
      for (int i = 0; i < per_phase; i++) begin
        send_byte(($urandom_range(0, 9) < 4) ? poll_match : 8'($urandom()));
      end
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_register_extremes();
    test_stray_bits();
    test_poll_pause();
    test_random(5, 18);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
